FILE: design/cfsp_pkg.sv
package cfsp_pkg;

  // Width of the internal byte offset counter; the reported position is its low bits.
  localparam int unsigned OffsetBits = 24;
  localparam int unsigned PosBits    = 24;

  typedef enum logic [2:0] {
    EV_POOL_ENTRY  = 3'd0,
    EV_ACCESS      = 3'd1,
    EV_FIELDS_CNT  = 3'd2,
    EV_METHODS_CNT = 3'd3,
    EV_METHOD      = 3'd4,
    EV_ATTR_CNT    = 3'd5,
    EV_BAD_TAG     = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } cfsp_in_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [PosBits-1:0] byte_position;
    logic [15:0]        item_index;
    logic [7:0]         tag_value;
  } cfsp_out_t;

endpackage

FILE: design/class_file_section_parser_core.sv
// Channel  Direction  Payload     Handshake
// in       input      cfsp_in_t   in_valid_i / in_stall_o
// out      output     cfsp_out_t  out_valid_o / out_stall_i
//
// One byte is taken every cycle while in_stall_o is low; each byte gives zero or one event.
// An event is registered in the output buffer before it appears at the output.
// A two-entry output buffer (head plus skid) holds events; in_stall_o rises
// only when both entries are occupied, and then holds the input.
// Reset clears the parser to idle with a zero offset; no clearing pass.
module class_file_section_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfsp_pkg::cfsp_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfsp_pkg::cfsp_out_t out_item_o
);
  import cfsp_pkg::*;

  logic      fire;
  logic      ev_valid;
  cfsp_out_t ev;
  logic      full;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  cfsp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  cfsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ev_valid),
    .push_item_i (ev),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: design/cfsp_parser.sv
module cfsp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  cfsp_pkg::cfsp_in_t item_i,
  output logic               ev_valid_o,
  output cfsp_pkg::cfsp_out_t ev_o
);
  import cfsp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE             = 4'd0,
    PH_HEADER           = 4'd1,
    PH_POOL_TAG         = 4'd2,
    PH_UTF8_LEN         = 4'd3,
    PH_POOL_BODY        = 4'd4,
    PH_CLASS_INFO       = 4'd5,
    PH_IFACE_SKIP       = 4'd6,
    PH_FIELDS_COUNT     = 4'd7,
    PH_FIELD_HEAD       = 4'd8,
    PH_FIELD_ATTR_HEAD  = 4'd9,
    PH_FIELD_ATTR_BODY  = 4'd10,
    PH_METHODS_COUNT    = 4'd11,
    PH_METHOD_HEAD      = 4'd12,
    PH_METHOD_ATTR_HEAD = 4'd13,
    PH_METHOD_ATTR_BODY = 4'd14,
    PH_ATTR_COUNT       = 4'd15
  } phase_e;

  typedef struct packed {
    logic       bad;
    logic [3:0] len;  // zero means a UTF8 entry with a length field
  } tag_info_t;

  localparam logic [OffsetBits-1:0] CntMax = '1;

  function automatic tag_info_t decode_tag(input logic [7:0] tag);
    tag_info_t r;
    r = '{bad: 1'b0, len: 4'd0};
    case (tag)
      8'd1:                                               r.len = 4'd0;
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18:       r.len = 4'd4;
      8'd5, 8'd6:                                         r.len = 4'd8;
      8'd7, 8'd8, 8'd16:                                  r.len = 4'd2;
      8'd15:                                              r.len = 4'd3;
      default:                                            r.bad = 1'b1;
    endcase
    return r;
  endfunction

  phase_e                ph_q, ph_d;
  logic [OffsetBits-1:0] cnt_q, cnt_d;
  logic [3:0]            fp_q, fp_d;
  logic [31:0]           skip_q, skip_d;
  logic [31:0]           vs_q, vs_d;
  logic [15:0]           el_q, el_d;
  logic [15:0]           ci_q, ci_d;
  logic [15:0]           al_q, al_d;

  logic [OffsetBits-1:0] pos;
  logic                  ev_v;
  event_kind_e           ev_kind;
  logic [15:0]           ev_idx;
  logic [7:0]            ev_tag;
  tag_info_t             ti;
  logic [7:0]            b;
  logic                  m;
  logic [15:0]           slots;

  always_comb begin
    b       = item_i.data_byte;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    fp_d    = fp_q;
    skip_d  = skip_q;
    vs_d    = vs_q;
    el_d    = el_q;
    ci_d    = ci_q;
    al_d    = al_q;
    ev_v    = 1'b0;
    ev_kind = EV_POOL_ENTRY;
    ev_idx  = '0;
    ev_tag  = '0;
    m       = 1'b0;
    slots   = 16'd1;
    ti      = decode_tag(b);

    // restart the parse from this byte
    if (item_i.file_start) begin
      ph_d   = PH_HEADER;
      cnt_d  = '0;
      fp_d   = '0;
      skip_d = '0;
      vs_d   = '0;
      el_d   = '0;
      ci_d   = '0;
      al_d   = '0;
    end

    pos = cnt_d;
    if (pos != CntMax) cnt_d = pos + 1'b1;

    vs_d = (fp_d == 4'd0) ? {24'd0, b} : {vs_d[23:0], b};

    case (ph_d)
      PH_HEADER: begin
        if (fp_d < 4'd9) begin
          fp_d = fp_d + 4'd1;
        end else begin
          el_d = (vs_d[15:0] > 16'd1) ? vs_d[15:0] - 16'd1 : 16'd0;
          ci_d = 16'd1;
          ph_d = (el_d != 16'd0) ? PH_POOL_TAG : PH_CLASS_INFO;
          fp_d = '0;
        end
      end
      PH_POOL_TAG: begin
        ev_v   = 1'b1;
        ev_idx = ci_d;
        ev_tag = b;
        if (ti.bad) begin
          ev_kind = EV_BAD_TAG;
          ph_d    = PH_IDLE;
        end else begin
          ev_kind = EV_POOL_ENTRY;
          slots   = (ti.len == 4'd8) ? 16'd2 : 16'd1;
          el_d    = (el_d > slots) ? el_d - slots : 16'd0;
          ci_d    = ci_d + slots;
          fp_d    = '0;
          if (ti.len == 4'd0) begin
            ph_d = PH_UTF8_LEN;
          end else begin
            skip_d = {28'd0, ti.len};
            ph_d   = PH_POOL_BODY;
          end
        end
      end
      PH_UTF8_LEN: begin
        if (fp_d < 4'd1) begin
          fp_d = 4'd1;
        end else begin
          skip_d = {16'd0, vs_d[15:0]};
          fp_d   = '0;
          if (skip_d != 32'd0) ph_d = PH_POOL_BODY;
          else ph_d = (el_d != 16'd0) ? PH_POOL_TAG : PH_CLASS_INFO;
        end
      end
      PH_POOL_BODY: begin
        fp_d   = '0;
        skip_d = skip_d - 32'd1;
        if (skip_d == 32'd0) ph_d = (el_d != 16'd0) ? PH_POOL_TAG : PH_CLASS_INFO;
      end
      PH_CLASS_INFO: begin
        if (fp_d == 4'd0) begin
          ev_v    = 1'b1;
          ev_kind = EV_ACCESS;
        end
        if (fp_d < 4'd7) begin
          fp_d = fp_d + 4'd1;
        end else begin
          skip_d = {15'd0, vs_d[15:0], 1'b0};
          fp_d   = '0;
          ph_d   = (skip_d != 32'd0) ? PH_IFACE_SKIP : PH_FIELDS_COUNT;
        end
      end
      PH_IFACE_SKIP: begin
        fp_d   = '0;
        skip_d = skip_d - 32'd1;
        if (skip_d == 32'd0) ph_d = PH_FIELDS_COUNT;
      end
      PH_FIELDS_COUNT, PH_METHODS_COUNT: begin
        m = (ph_d == PH_METHODS_COUNT);
        if (fp_d == 4'd0) begin
          ev_v    = 1'b1;
          ev_kind = m ? EV_METHODS_CNT : EV_FIELDS_CNT;
          fp_d    = 4'd1;
        end else begin
          el_d = vs_d[15:0];
          ci_d = '0;
          fp_d = '0;
          if (el_d != 16'd0) ph_d = m ? PH_METHOD_HEAD : PH_FIELD_HEAD;
          else ph_d = m ? PH_ATTR_COUNT : PH_METHODS_COUNT;
        end
      end
      PH_FIELD_HEAD, PH_METHOD_HEAD: begin
        m = (ph_d == PH_METHOD_HEAD);
        if (m && fp_d == 4'd0) begin
          ev_v    = 1'b1;
          ev_kind = EV_METHOD;
          ev_idx  = ci_d;
        end
        if (fp_d < 4'd7) begin
          fp_d = fp_d + 4'd1;
        end else begin
          al_d = vs_d[15:0];
          fp_d = '0;
          if (al_d != 16'd0) begin
            ph_d = m ? PH_METHOD_ATTR_HEAD : PH_FIELD_ATTR_HEAD;
          end else begin
            el_d = el_d - 16'd1;
            ci_d = ci_d + 16'd1;
            if (el_d != 16'd0) ph_d = m ? PH_METHOD_HEAD : PH_FIELD_HEAD;
            else ph_d = m ? PH_ATTR_COUNT : PH_METHODS_COUNT;
          end
        end
      end
      PH_FIELD_ATTR_HEAD, PH_METHOD_ATTR_HEAD,
      PH_FIELD_ATTR_BODY, PH_METHOD_ATTR_BODY: begin
        m = (ph_d == PH_METHOD_ATTR_HEAD) || (ph_d == PH_METHOD_ATTR_BODY);
        if ((ph_d == PH_FIELD_ATTR_HEAD || ph_d == PH_METHOD_ATTR_HEAD) && fp_d < 4'd5) begin
          fp_d = fp_d + 4'd1;
        end else begin
          if (ph_d == PH_FIELD_ATTR_HEAD || ph_d == PH_METHOD_ATTR_HEAD) begin
            skip_d = vs_d;
          end else begin
            skip_d = skip_d - 32'd1;
          end
          fp_d = '0;
          if ((ph_d == PH_FIELD_ATTR_HEAD || ph_d == PH_METHOD_ATTR_HEAD)
              && skip_d != 32'd0) begin
            ph_d = m ? PH_METHOD_ATTR_BODY : PH_FIELD_ATTR_BODY;
          end else if (skip_d == 32'd0) begin
            // attribute finished; advance to the next one, the next member or the next section
            al_d = al_d - 16'd1;
            if (al_d != 16'd0) begin
              ph_d = m ? PH_METHOD_ATTR_HEAD : PH_FIELD_ATTR_HEAD;
            end else begin
              el_d = el_d - 16'd1;
              ci_d = ci_d + 16'd1;
              if (el_d != 16'd0) ph_d = m ? PH_METHOD_HEAD : PH_FIELD_HEAD;
              else ph_d = m ? PH_ATTR_COUNT : PH_METHODS_COUNT;
            end
          end
        end
      end
      PH_ATTR_COUNT: begin
        if (fp_d == 4'd0) begin
          ev_v    = 1'b1;
          ev_kind = EV_ATTR_CNT;
          fp_d    = 4'd1;
        end else begin
          fp_d = '0;
          ph_d = PH_IDLE;
        end
      end
      default: begin
        fp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      fp_q   <= '0;
      skip_q <= '0;
      vs_q   <= '0;
      el_q   <= '0;
      ci_q   <= '0;
      al_q   <= '0;
    end else if (fire_i) begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      fp_q   <= fp_d;
      skip_q <= skip_d;
      vs_q   <= vs_d;
      el_q   <= el_d;
      ci_q   <= ci_d;
      al_q   <= al_d;
    end
  end

  assign ev_valid_o       = fire_i && ev_v;
  assign ev_o.event_kind    = ev_kind;
  assign ev_o.byte_position = PosBits'(pos);
  assign ev_o.item_index    = ev_idx;
  assign ev_o.tag_value     = ev_tag;

  a_bad_tag_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && ev_kind == EV_BAD_TAG) |=> (ph_q == PH_IDLE))
    else $error("parser not idle after bad tag");

  a_restart_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.file_start) |=> (cnt_q == OffsetBits'(1)))
    else $error("offset counter not restarted");

  a_no_ev_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o |-> (ph_q != PH_IDLE || item_i.file_start))
    else $error("event raised while idle");

endmodule

FILE: design/cfsp_out_buf.sv
module cfsp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfsp_pkg::cfsp_out_t push_item_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfsp_pkg::cfsp_out_t out_item_o
);
  import cfsp_pkg::*;

  logic      head_v_q, head_v_d;
  logic      skid_v_q, skid_v_d;
  cfsp_out_t head_q, head_d;
  cfsp_out_t skid_q, skid_d;
  logic      pop;

  assign pop = head_v_q && !out_stall_i;

  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (pop || !head_v_q) begin
      // head is free: refill from skid first, then from the new item
      if (skid_v_q) begin
        head_v_d = 1'b1;
        head_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = push_item_i;
      end else begin
        head_v_d = push_i;
        head_d   = push_item_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_item_o  = head_q;

  a_skid_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("skid entry held without head entry");

endmodule
